### rtl/hs_pkg.sv
// Shared types for the heap sorter: request and result payloads, and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hs_pkg;

  // Default store depth
  localparam int DEPTH_DEF = 64;

  // Input request payload
  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               final_item;
  } in_t;

  // Result payload
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_run;
    logic               overflowed;
  } out_t;

  // Read address sources
  typedef enum logic [2:0] {
    RD_KM1,
    RD_LC,
    RD_RC,
    RD_CHILD_LC,
    RD_ROOT,
    RD_K,
    RD_OUT
  } rd_sel_t;

  // Write address/data sources
  typedef enum logic [1:0] {
    WR_LOAD,
    WR_BEST,
    WR_HOLE,
    WR_ROOT
  } wr_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    sort_init;
    logic    build_pick;
    logic    heap_init;
    logic    heap_pick;
    logic    cap_v;
    logic    cap_root;
    logic    cap_lc;
    logic    cap_rc;
    logic    descend;
    logic    out_init;
    logic    out_step;
    logic    out_emit;
    logic    clear;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic k_zero;
    logic lc_in;
    logic rc_in;
    logic pick_none;
    logic child_lc_in;
    logic out_last;
  } sts_t;

endpackage

`default_nettype wire

### rtl/hs_dpath.sv
// Heap sorter datapath: value store, sift registers, index counters, result
// register. Driven by hs_ctrl through cmd_t; depends on hs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hs_dpath
  import hs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_t  in_data,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;

  typedef enum logic [1:0] {
    PICK_NONE,
    PICK_LC,
    PICK_RC
  } pick_t;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;

  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [AW-1:0] node_r, node_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic signed [31:0] v_r, v_nxt;
  logic signed [31:0] root_r, root_nxt;
  logic signed [31:0] best_r, best_nxt;
  pick_t         pick_r, pick_nxt;
  logic          emit_r, emit_nxt;
  logic          last_r, last_nxt;

  logic [XW-1:0] lc, rc, child_lc, len_x;
  logic [AW-1:0] child;
  logic          room;
  logic [AW-1:0] raddr, waddr;
  logic signed [31:0] wdata;
  logic          wr_go;

  // Child indices of the current node and of the chosen child
  assign lc       = {1'b0, node_r, 1'b1};
  assign rc       = lc + XW'(1);
  assign child    = (pick_r == PICK_LC) ? lc[AW-1:0] : rc[AW-1:0];
  assign child_lc = {1'b0, child, 1'b1};
  assign len_x    = XW'(len_r);
  assign room     = count_r < CW'(DEPTH);

  // Status back to the controller
  always_comb begin
    sts.k_zero      = (k_r == '0);
    sts.lc_in       = (lc < len_x);
    sts.rc_in       = (rc < len_x);
    sts.pick_none   = (pick_r == PICK_NONE);
    sts.child_lc_in = (child_lc < len_x);
    sts.out_last    = ((XW'(idx_r) + XW'(1)) == XW'(count_r));
  end

  // Read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_KM1:      raddr = k_r - AW'(1);
      RD_LC:       raddr = lc[AW-1:0];
      RD_RC:       raddr = rc[AW-1:0];
      RD_CHILD_LC: raddr = child_lc[AW-1:0];
      RD_ROOT:     raddr = '0;
      RD_K:        raddr = k_r;
      RD_OUT:      raddr = idx_r;
      default:     raddr = '0;
    endcase
  end

  // Write address and data select; drop a load when the store is full
  always_comb begin
    wr_go = cmd.wr_en;
    case (cmd.wr_sel)
      WR_LOAD: begin
        waddr = count_r[AW-1:0];
        wdata = in_data.sample_value;
        wr_go = cmd.wr_en & room;
      end
      WR_BEST: begin
        waddr = node_r;
        wdata = best_r;
      end
      WR_HOLE: begin
        waddr = node_r;
        wdata = v_r;
      end
      WR_ROOT: begin
        waddr = k_r;
        wdata = root_r;
      end
      default: begin
        waddr = node_r;
        wdata = v_r;
      end
    endcase
  end

  // Value store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= raddr < AW'(DEPTH - 1) || raddr == AW'(DEPTH - 1) ? mem[raddr] : '0;
    end
  end

  // Next-state of counters and sift registers
  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    k_nxt     = k_r;
    len_nxt   = len_r;
    node_nxt  = node_r;
    idx_nxt   = idx_r;
    v_nxt     = v_r;
    root_nxt  = root_r;
    best_nxt  = best_r;
    pick_nxt  = pick_r;
    emit_nxt  = cmd.out_emit;
    last_nxt  = cmd.out_emit & sts.out_last;

    // Count or drop an incoming value
    if (cmd.load) begin
      if (room) begin
        count_nxt = count_r + CW'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end
    if (cmd.sort_init) begin
      k_nxt = AW'(count_r >> 1);
    end
    if (cmd.heap_init) begin
      k_nxt = AW'(count_r - CW'(1));
    end
    // Start a build sift at node k-1 over the whole set
    if (cmd.build_pick) begin
      node_nxt = k_r - AW'(1);
      len_nxt  = count_r;
      k_nxt    = k_r - AW'(1);
    end
    // Start an extraction sift at the root over the shrunk heap
    if (cmd.heap_pick) begin
      node_nxt = '0;
      len_nxt  = CW'(k_r);
      k_nxt    = k_r - AW'(1);
    end
    if (cmd.cap_v) begin
      v_nxt = rdata_r;
    end
    if (cmd.cap_root) begin
      root_nxt = rdata_r;
    end
    // Compare left child against the carried value
    if (cmd.cap_lc) begin
      if (rdata_r > v_r) begin
        best_nxt = rdata_r;
        pick_nxt = PICK_LC;
      end else begin
        best_nxt = v_r;
        pick_nxt = PICK_NONE;
      end
    end
    // Compare right child against the best so far
    if (cmd.cap_rc) begin
      if (rdata_r > best_r) begin
        best_nxt = rdata_r;
        pick_nxt = PICK_RC;
      end
    end
    if (cmd.descend) begin
      node_nxt = child;
    end
    if (cmd.out_init) begin
      idx_nxt = '0;
    end
    if (cmd.out_step) begin
      idx_nxt = idx_r + AW'(1);
    end
    if (cmd.clear) begin
      count_nxt = '0;
      drop_nxt  = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
      emit_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    len_r  <= len_nxt;
    node_r <= node_nxt;
    idx_r  <= idx_nxt;
    v_r    <= v_nxt;
    root_r <= root_nxt;
    best_r <= best_nxt;
    pick_r <= pick_nxt;
    last_r <= last_nxt;
  end

  // Result: read data registered in the cycle after its address
  assign out_valid             = emit_r;
  assign out_data.sorted_value = rdata_r;
  assign out_data.end_of_run   = last_r;
  assign out_data.overflowed   = drop_r;

endmodule

`default_nettype wire

### rtl/hs_ctrl.sv
// Heap sorter controller: one-hot state machine that sequences loading,
// heap build, root extraction and readout. Depends on hs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hs_ctrl
  import hs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic in_final,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_SORT_INIT = 13'b0000000000010,
    S_BLD_NEXT  = 13'b0000000000100,
    S_SD_LOADV  = 13'b0000000001000,
    S_SD_START  = 13'b0000000010000,
    S_SD_LC     = 13'b0000000100000,
    S_SD_RC     = 13'b0000001000000,
    S_SD_DEC    = 13'b0000010000000,
    S_SD_FIN    = 13'b0000100000000,
    S_HP_NEXT   = 13'b0001000000000,
    S_HP_RD0    = 13'b0010000000000,
    S_HP_RDK    = 13'b0100000000000,
    S_OUT_RD    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   heap_phase_r, heap_phase_nxt;
  state_t ret_state;
  logic   clear_r;

  // Where a finished sift returns to
  assign ret_state = heap_phase_r ? S_HP_NEXT : S_BLD_NEXT;
  // Stay busy through the cycle that carries the last result
  assign busy      = (state_r != S_IDLE) || clear_r;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    heap_phase_nxt = heap_phase_r;
    cmd            = '0;
    cmd.clear      = clear_r;
    case (state_r)
      S_IDLE: begin
        if (start && !clear_r) begin
          cmd.load   = 1'b1;
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_LOAD;
          if (in_final) begin
            state_nxt = S_SORT_INIT;
          end
        end
      end
      S_SORT_INIT: begin
        cmd.sort_init  = 1'b1;
        heap_phase_nxt = 1'b0;
        state_nxt      = S_BLD_NEXT;
      end
      // Walk build nodes from the last parent down to the root
      S_BLD_NEXT: begin
        if (sts.k_zero) begin
          cmd.heap_init  = 1'b1;
          heap_phase_nxt = 1'b1;
          state_nxt      = S_HP_NEXT;
        end else begin
          cmd.build_pick = 1'b1;
          cmd.rd_en      = 1'b1;
          cmd.rd_sel     = RD_KM1;
          state_nxt      = S_SD_LOADV;
        end
      end
      S_SD_LOADV: begin
        cmd.cap_v = 1'b1;
        state_nxt = S_SD_START;
      end
      S_SD_START: begin
        if (sts.lc_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LC;
          state_nxt  = S_SD_LC;
        end else begin
          state_nxt = S_SD_FIN;
        end
      end
      S_SD_LC: begin
        cmd.cap_lc = 1'b1;
        if (sts.rc_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_RC;
          state_nxt  = S_SD_RC;
        end else begin
          state_nxt = S_SD_DEC;
        end
      end
      S_SD_RC: begin
        cmd.cap_rc = 1'b1;
        state_nxt  = S_SD_DEC;
      end
      // Settle the carried value here, or move the larger child up
      S_SD_DEC: begin
        cmd.wr_en = 1'b1;
        if (sts.pick_none) begin
          cmd.wr_sel = WR_HOLE;
          state_nxt  = ret_state;
        end else begin
          cmd.wr_sel  = WR_BEST;
          cmd.descend = 1'b1;
          if (sts.child_lc_in) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CHILD_LC;
            state_nxt  = S_SD_LC;
          end else begin
            state_nxt = S_SD_FIN;
          end
        end
      end
      S_SD_FIN: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_HOLE;
        state_nxt  = ret_state;
      end
      // Extract the root into slot k, then sift the old slot-k value down
      S_HP_NEXT: begin
        if (sts.k_zero) begin
          cmd.out_init = 1'b1;
          state_nxt    = S_OUT_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ROOT;
          state_nxt  = S_HP_RD0;
        end
      end
      S_HP_RD0: begin
        cmd.cap_root = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_K;
        state_nxt    = S_HP_RDK;
      end
      S_HP_RDK: begin
        cmd.cap_v     = 1'b1;
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = WR_ROOT;
        cmd.heap_pick = 1'b1;
        state_nxt     = S_SD_START;
      end
      // Stream the sorted store out, one result per cycle
      S_OUT_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_OUT;
        cmd.out_emit = 1'b1;
        cmd.out_step = 1'b1;
        if (sts.out_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the last result's flags, then clear the set on return to idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      heap_phase_r <= 1'b0;
      clear_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      heap_phase_r <= heap_phase_nxt;
      clear_r      <= (state_r == S_OUT_RD) && sts.out_last;
    end
  end

endmodule

`default_nettype wire

### rtl/heap_sorter_top.sv
// Heap sorter top level: joins hs_ctrl and hs_dpath and checks the start,
// busy and result behavior. Depends on hs_pkg, hs_ctrl, hs_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Collects signed 32-bit values, one per start request taken while busy is
// low, into a store of DEPTH entries; values past DEPTH are dropped and mark
// every result of that set as overflowed. A request with final_item set ends
// the set: busy rises and the block heap-sorts the stored values through a
// single-read, single-write store; each tree level of a sift reads the left
// child, reads the right child if there is one, and decides, and each sift
// also fetches and settles the carried value. Then the results follow on
// out_valid back to back, ascending, the last marked with end_of_run; busy
// falls after the cycle of the last result.
// Results are not held: the receiver must take each one in its cycle.
// Loading a non-final value gives no result.
module heap_sorter_top
  import hs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  cmd_t cmd;
  sts_t sts;

  hs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_final (in_data.final_item),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  hs_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Results only come out during a sort
  a_out_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside a sort");

  // A final request starts the sort
  a_final_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.final_item) |=> busy)
    else $error("final request did not start the sort");

  // A non-final request leaves the block ready
  a_load_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.final_item) |=> (!busy && !out_valid))
    else $error("non-final request did not return to idle");

  // The last result ends the run
  a_last_ends : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.end_of_run) |=> !out_valid)
    else $error("result after end of run");

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for heap_sorter_top: drives sets of signed values
// and checks every sorted result against an in-bench prediction.
// Depends on hs_pkg and the heap sorter RTL.
`timescale 1ns / 1ps

module tb;
  import hs_pkg::*;

  localparam int SET_CAP     = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 400;
  localparam int ITEM_TARGET = 450;
  localparam int VAL_MIN     = 32'h8000_0000;
  localparam int VAL_MAX     = 32'h7fff_ffff;

  // Value flavors for random sets
  typedef enum int {
    MIX_WIDE,
    MIX_NARROW,
    MIX_EDGE
  } value_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  // Requests waiting to be sent, results predicted but not yet seen
  in_t  pending_reqs[$];
  out_t due_results[$];

  // Predicted set contents
  int   set_vals[$];
  logic set_dropped = 1'b0;

  int   burst_left = 0;
  int   gap_left = 0;
  int   miss_count = 0;
  int   cycle_count = 0;
  int   queued_items = 0;
  logic go;

  heap_sorter_top #(.DEPTH(SET_CAP)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Fold one accepted request into the set; on the last one, sort and
  // queue the expected results. Equal values come out the same either way.
  task automatic predict_sample(input in_t s);
    int   n;
    int   v;
    int   j;
    out_t r;
    if (set_vals.size() < SET_CAP) begin
      set_vals.push_back(s.sample_value);
    end else begin
      set_dropped = 1'b1;
    end
    if (s.final_item) begin
      n = set_vals.size();
      for (int i = 1; i < n; i++) begin
        v = set_vals[i];
        j = i - 1;
        while (j >= 0 && set_vals[j] > v) begin
          set_vals[j + 1] = set_vals[j];
          j--;
        end
        set_vals[j + 1] = v;
      end
      for (int i = 0; i < n; i++) begin
        r.sorted_value = set_vals[i];
        r.end_of_run   = (i == n - 1);
        r.overflowed   = set_dropped;
        due_results.push_back(r);
      end
      set_vals.delete();
      set_dropped = 1'b0;
    end
  endtask

  function automatic void add_req(input int v, input logic fin);
    in_t r;
    r.sample_value = v;
    r.final_item   = fin;
    pending_reqs.push_back(r);
    queued_items++;
  endfunction

  function automatic int pick_value(input value_mix_t mix);
    case (mix)
      MIX_WIDE:   return $urandom;
      MIX_NARROW: return int'($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 5))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return 0;
          3:       return -1;
          4:       return 1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Driver: send queued requests in bursts separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_sample(pending_reqs.pop_front());
        if (burst_left != 0) burst_left--;
      end
      if (gap_left != 0) begin
        gap_left--;
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      go = (pending_reqs.size() != 0) && (gap_left == 0) && (burst_left != 0);
      start <= go;
      if (go) in_data <= pending_reqs[0];
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        miss_count++;
        if (miss_count <= 10)
          $display("unexpected result: value %0d last %0b ovf %0b",
                   out_data.sorted_value, out_data.end_of_run, out_data.overflowed);
      end else if (out_data.sorted_value !== due_results[0].sorted_value ||
                   out_data.end_of_run !== due_results[0].end_of_run ||
                   out_data.overflowed !== due_results[0].overflowed) begin
        miss_count++;
        if (miss_count <= 10)
          $display("mismatch: exp value %0d last %0b ovf %0b, got value %0d last %0b ovf %0b",
                   due_results[0].sorted_value, due_results[0].end_of_run,
                   due_results[0].overflowed, out_data.sorted_value,
                   out_data.end_of_run, out_data.overflowed);
        void'(due_results.pop_front());
      end else begin
        void'(due_results.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int         n;
    value_mix_t mix;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sets: single extremes, full-range pair, mixed signs,
    // duplicates, descending and ascending runs
    add_req(VAL_MIN, 1'b1);
    add_req(VAL_MAX, 1'b1);
    add_req(VAL_MAX, 1'b0);
    add_req(VAL_MIN, 1'b1);
    add_req(0, 1'b0);
    add_req(-1, 1'b0);
    add_req(1, 1'b0);
    add_req(VAL_MAX, 1'b0);
    add_req(VAL_MIN, 1'b1);
    add_req(5, 1'b0);
    add_req(5, 1'b0);
    add_req(5, 1'b0);
    add_req(-5, 1'b1);
    add_req(VAL_MAX, 1'b0);
    add_req(100, 1'b0);
    add_req(0, 1'b0);
    add_req(-100, 1'b0);
    add_req(VAL_MIN, 1'b1);
    add_req(VAL_MIN, 1'b0);
    add_req(-1, 1'b0);
    add_req(0, 1'b0);
    add_req(1, 1'b0);
    add_req(VAL_MAX, 1'b1);

    // Hold off until the directed sets have fully drained
    while (pending_reqs.size() != 0 || due_results.size() != 0) @(posedge clk);

    // Random sets: mostly small, some exactly full, some overflowing
    while (queued_items < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0:       n = SET_CAP;
        1:       n = SET_CAP + $urandom_range(1, 8);
        2, 3, 4: n = $urandom_range(1, 4);
        default: n = $urandom_range(1, 16);
      endcase
      mix = value_mix_t'($urandom_range(0, 2));
      for (int i = 0; i < n; i++) add_req(pick_value(mix), i == n - 1);
      // Let the queue drain a bit so gaps interleave with sorting
      while (pending_reqs.size() > 32) @(posedge clk);
    end

    // Drain all requests and results, then watch for strays
    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (miss_count == 0 && due_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hs_pkg.sv
rtl/hs_dpath.sv
rtl/hs_ctrl.sv
rtl/heap_sorter_top.sv
dv/tb.sv
